// ===== rtl/core/qrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// shared widths, result codes and stage word types of the root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_WIDTH = 16;
	localparam int FRAC       = 16;
	localparam int ROOT_WIDTH = 40;

	// nonnegative discriminant width
	localparam int DW   = 2 * COEF_WIDTH + 1;
	// root width of the scaled square root, radicand padded to twice that
	localparam int SW   = (DW + 2 * FRAC + 1) / 2;
	localparam int NW   = 2 * SW;
	localparam int RW   = SW + 2;
	// -b scaled by the fraction bits
	localparam int NBW  = COEF_WIDTH + FRAC + 1;
	// numerator (-b +/- sqrt) width, signed
	localparam int NUMW = ((NBW > SW + 1) ? NBW : SW + 1) + 1;
	// magnitude of 2a
	localparam int DENW = COEF_WIDTH + 1;
	localparam int DRW  = DENW + 1;

	typedef enum logic [1:0] {
		CASE_NONE   = 2'd0,
		CASE_ONE    = 2'd1,
		CASE_TWO    = 2'd2,
		CASE_LINEAR = 2'd3
	} root_case_t;

	typedef struct packed {
		root_case_t             rc;
		logic signed [NBW-1:0]  nb;
		logic [DENW-1:0]        den;
		logic                   den_neg;
	} sq_meta_t;

	typedef struct packed {
		root_case_t       rc;
		logic [NUMW-1:0]  mag_p;
		logic [NUMW-1:0]  mag_m;
		logic [DENW-1:0]  den;
		logic             neg_p;
		logic             neg_m;
	} div_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/qrs_disc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_disc
// two stages: coefficient products, then discriminant and root case
// ----------------------------------------------------------------------------
module qrs_disc (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  v_in,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] a_in,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] b_in,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] c_in,
	output logic                                       v_out,
	output logic [qrs_pkg::DW-1:0]                     rad_out,
	output qrs_pkg::sq_meta_t                          meta_out
);
	import qrs_pkg::*;

	logic                           v_s1;
	logic signed [2*COEF_WIDTH-1:0] bb_s1;
	logic signed [2*COEF_WIDTH-1:0] ac_s1;
	logic signed [COEF_WIDTH-1:0]   a_s1;
	logic signed [COEF_WIDTH-1:0]   b_s1;

	logic signed [DW:0]             d;
	logic [COEF_WIDTH:0]            a_ext;
	logic [COEF_WIDTH:0]            a_mag;
	root_case_t                     rc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= b_in * b_in;
			ac_s1 <= a_in * c_in;
			a_s1  <= a_in;
			b_s1  <= b_in;
		end
	end

	always_comb begin
		d     = (DW + 1)'(bb_s1) - ((DW + 1)'(ac_s1) <<< 2);
		a_ext = (COEF_WIDTH + 1)'(a_s1);
		a_mag = a_s1[COEF_WIDTH-1] ? (~a_ext + 1'b1) : a_ext;
		if (a_s1 == '0) begin
			rc = CASE_LINEAR;
		end else if (d[DW]) begin
			rc = CASE_NONE;
		end else if (d == '0) begin
			rc = CASE_ONE;
		end else begin
			rc = CASE_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_out          <= d[DW] ? '0 : d[DW-1:0];
			meta_out.rc      <= rc;
			meta_out.nb      <= -(NBW'(b_s1) <<< FRAC);
			meta_out.den     <= {a_mag[COEF_WIDTH-1:0], 1'b0};
			meta_out.den_neg <= a_s1[COEF_WIDTH-1];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/qrs_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_sqrt
// digit-by-digit integer square root, one root bit per pipeline stage
// ----------------------------------------------------------------------------
module qrs_sqrt (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  v_in,
	input  wire logic [qrs_pkg::DW-1:0] rad_in,
	input  wire qrs_pkg::sq_meta_t     meta_in,
	output logic                       v_out,
	output logic [qrs_pkg::SW-1:0]     root_out,
	output qrs_pkg::sq_meta_t          meta_out
);
	import qrs_pkg::*;

	logic              v_q    [SW];
	logic [RW-1:0]     rem_q  [SW];
	logic [SW-1:0]     root_q [SW];
	logic [NW-1:0]     rest_q [SW];
	sq_meta_t          meta_q [SW];

	logic [NW-1:0]     rad_full;

	// radicand scaled by 2^(2*FRAC)
	assign rad_full = NW'(rad_in) << (2 * FRAC);

	for (genvar k = 0; k < SW; k++) begin : g_stage
		logic          v_p;
		logic [RW-1:0] rem_p;
		logic [SW-1:0] root_p;
		logic [NW-1:0] rest_p;
		sq_meta_t      meta_p;
		logic [RW-1:0] r2;
		logic [RW-1:0] t;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_p    = v_in;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rest_p = rad_full;
			assign meta_p = meta_in;
		end else begin : g_next
			assign v_p    = v_q[k-1];
			assign rem_p  = rem_q[k-1];
			assign root_p = root_q[k-1];
			assign rest_p = rest_q[k-1];
			assign meta_p = meta_q[k-1];
		end

		always_comb begin
			r2 = {rem_p[RW-3:0], rest_p[NW-1:NW-2]};
			t  = {root_p, 2'b01};
			ge = (r2 >= t);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? (r2 - t) : r2;
				root_q[k] <= {root_p[SW-2:0], ge};
				rest_q[k] <= {rest_p[NW-3:0], 2'b00};
				meta_q[k] <= meta_p;
			end
		end
	end

	assign v_out    = v_q[SW-1];
	assign root_out = root_q[SW-1];
	assign meta_out = meta_q[SW-1];

endmodule
`default_nettype wire

// ===== rtl/core/qrs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div
// two-lane restoring divider on magnitudes, one quotient bit per stage
// ----------------------------------------------------------------------------
module qrs_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               v_in,
	input  wire qrs_pkg::div_word_t w_in,
	output logic                    v_out,
	output qrs_pkg::div_word_t      w_out
);
	import qrs_pkg::*;

	// mag fields hold the shifting numerator and collect quotient bits
	logic          v_q   [NUMW];
	div_word_t     w_q   [NUMW];
	logic [DENW-1:0] remp_q [NUMW];
	logic [DENW-1:0] remm_q [NUMW];

	for (genvar k = 0; k < NUMW; k++) begin : g_stage
		logic            v_p;
		div_word_t       w_p;
		logic [DENW-1:0] remp_p;
		logic [DENW-1:0] remm_p;
		logic [DRW-1:0]  rp2;
		logic [DRW-1:0]  rm2;
		logic [DRW-1:0]  dd;
		logic            gep;
		logic            gem;
		div_word_t       w_n;

		if (k == 0) begin : g_first
			assign v_p    = v_in;
			assign w_p    = w_in;
			assign remp_p = '0;
			assign remm_p = '0;
		end else begin : g_next
			assign v_p    = v_q[k-1];
			assign w_p    = w_q[k-1];
			assign remp_p = remp_q[k-1];
			assign remm_p = remm_q[k-1];
		end

		always_comb begin
			dd        = {1'b0, w_p.den};
			rp2       = {remp_p, w_p.mag_p[NUMW-1]};
			rm2       = {remm_p, w_p.mag_m[NUMW-1]};
			gep       = (rp2 >= dd);
			gem       = (rm2 >= dd);
			w_n       = w_p;
			w_n.mag_p = {w_p.mag_p[NUMW-2:0], gep};
			w_n.mag_m = {w_p.mag_m[NUMW-2:0], gem};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_q[k]    <= w_n;
				remp_q[k] <= gep ? DENW'(rp2 - dd) : DENW'(rp2);
				remm_q[k] <= gem ? DENW'(rm2 - dd) : DENW'(rm2);
			end
		end
	end

	assign v_out = v_q[NUMW-1];
	assign w_out = w_q[NUMW-1];

endmodule
`default_nettype wire

// ===== rtl/core/quadratic_root_solver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: discriminant stages, SW square root stages, numerator register, NUMW
//   divider stages, output register (33 square root and 35 divider stages by default)
// throughput: one coefficient word per cycle while the result is not stalled, set by
//   the one-bit-per-stage square root and divider pipelines
// a stalled result freezes the whole pipeline; it keeps accepting while the output slot is empty
// reset clears only the valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x*x + b*x + c in fixed point, fully pipelined
// ----------------------------------------------------------------------------
module quadratic_root_solver (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_a,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_b,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_c,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [1:0]                                 root_case,
	output logic signed [qrs_pkg::ROOT_WIDTH-1:0]      root_plus,
	output logic signed [qrs_pkg::ROOT_WIDTH-1:0]      root_minus
);
	import qrs_pkg::*;

	// width for the saturating compare
	localparam int XW = (NUMW + 1 > ROOT_WIDTH) ? NUMW + 1 : ROOT_WIDTH;

	logic            en;

	logic            disc_v;
	logic [DW-1:0]   disc_rad;
	sq_meta_t        disc_meta;

	logic            sq_v;
	logic [SW-1:0]   sq_root;
	sq_meta_t        sq_meta;

	logic signed [NUMW-1:0] num_p;
	logic signed [NUMW-1:0] num_m;
	div_word_t       prep_w;
	logic            v_s3;
	div_word_t       w_s3;

	logic            dv_v;
	div_word_t       dv_w;

	logic signed [NUMW:0]   q_p;
	logic signed [NUMW:0]   q_m;
	logic signed [XW-1:0]   qx_p;
	logic signed [XW-1:0]   qx_m;
	logic signed [XW-1:0]   x_max;
	logic signed [XW-1:0]   x_min;
	logic signed [ROOT_WIDTH-1:0] sat_p;
	logic signed [ROOT_WIDTH-1:0] sat_m;

	// the whole pipe moves whenever the output slot is free or being taken
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1-2: products, discriminant, case
	qrs_disc u_disc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (in_valid),
		.a_in     (coef_a),
		.b_in     (coef_b),
		.c_in     (coef_c),
		.v_out    (disc_v),
		.rad_out  (disc_rad),
		.meta_out (disc_meta)
	);

	// floor(sqrt(D * 2^(2*FRAC)))
	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (disc_v),
		.rad_in   (disc_rad),
		.meta_in  (disc_meta),
		.v_out    (sq_v),
		.root_out (sq_root),
		.meta_out (sq_meta)
	);

	// numerators -b*2^FRAC +/- sqrt, split into sign and magnitude
	always_comb begin
		num_p        = NUMW'(sq_meta.nb) + $signed(NUMW'(sq_root));
		num_m        = NUMW'(sq_meta.nb) - $signed(NUMW'(sq_root));
		prep_w.rc    = sq_meta.rc;
		prep_w.den   = sq_meta.den;
		prep_w.mag_p = num_p[NUMW-1] ? NUMW'(-num_p) : NUMW'(num_p);
		prep_w.mag_m = num_m[NUMW-1] ? NUMW'(-num_m) : NUMW'(num_m);
		prep_w.neg_p = num_p[NUMW-1] ^ sq_meta.den_neg;
		prep_w.neg_m = num_m[NUMW-1] ^ sq_meta.den_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s3 <= prep_w;
		end
	end

	// truncating division of both numerators by 2a
	qrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s3),
		.w_in   (w_s3),
		.v_out  (dv_v),
		.w_out  (dv_w)
	);

	// restore sign, saturate to the root range, zero the unused cases
	always_comb begin
		q_p   = dv_w.neg_p ? -$signed({1'b0, dv_w.mag_p}) : $signed({1'b0, dv_w.mag_p});
		q_m   = dv_w.neg_m ? -$signed({1'b0, dv_w.mag_m}) : $signed({1'b0, dv_w.mag_m});
		qx_p  = XW'(q_p);
		qx_m  = XW'(q_m);
		x_max = $signed({{(XW - ROOT_WIDTH + 1){1'b0}}, {(ROOT_WIDTH - 1){1'b1}}});
		x_min = ~x_max;
		if (qx_p > x_max) begin
			sat_p = x_max[ROOT_WIDTH-1:0];
		end else if (qx_p < x_min) begin
			sat_p = x_min[ROOT_WIDTH-1:0];
		end else begin
			sat_p = qx_p[ROOT_WIDTH-1:0];
		end
		if (qx_m > x_max) begin
			sat_m = x_max[ROOT_WIDTH-1:0];
		end else if (qx_m < x_min) begin
			sat_m = x_min[ROOT_WIDTH-1:0];
		end else begin
			sat_m = qx_m[ROOT_WIDTH-1:0];
		end
		if (dv_w.rc == CASE_NONE || dv_w.rc == CASE_LINEAR) begin
			sat_p = '0;
			sat_m = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_case  <= dv_w.rc;
			root_plus  <= sat_p;
			root_minus <= sat_m;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/qrs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_checker
// port-level checks on the root solver, bound to the top level
// ----------------------------------------------------------------------------
module qrs_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_stall,
	input wire logic                                  out_valid,
	input wire logic                                  out_stall,
	input wire logic [1:0]                            root_case,
	input wire logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_plus,
	input wire logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_minus
);
	import qrs_pkg::*;

	// input side only stalls behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// a held result keeps its word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(root_case)
			&& $stable(root_plus) && $stable(root_minus)))
		else $error("stalled result changed");

	// no roots reported in the no-root and linear cases
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (root_case == CASE_NONE || root_case == CASE_LINEAR))
			|-> (root_plus == '0 && root_minus == '0))
		else $error("root fields not zero");

	// double root gives equal fields
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && root_case == CASE_ONE) |-> (root_plus == root_minus))
		else $error("double root fields differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.root_case  (root_case),
	.root_plus  (root_plus),
	.root_minus (root_minus)
);
`default_nettype wire
